// ===== hw/rtl/acs_pkg.sv =====
// Shared types, opcodes and sizes for the accumulator CPU step block.
package acs_pkg;

  localparam int WORD_W        = 16;
  localparam int PC_W          = 7;
  localparam int OP_W          = 8;
  localparam int ROM_DEPTH_DEF = 128;
  localparam int RAM_DEPTH_DEF = 128;
  localparam int QDEPTH        = 2;
  localparam int QAW           = $clog2(QDEPTH);

  localparam logic [OP_W-1:0] OP_LDA = 8'h01;
  localparam logic [OP_W-1:0] OP_STA = 8'h02;
  localparam logic [OP_W-1:0] OP_ADD = 8'h03;
  localparam logic [OP_W-1:0] OP_OUT = 8'h05;
  localparam logic [OP_W-1:0] OP_JMP = 8'h06;
  localparam logic [OP_W-1:0] OP_JC  = 8'h07;
  localparam logic [OP_W-1:0] OP_JZ  = 8'h08;
  localparam logic [OP_W-1:0] OP_HLT = 8'h0A;
  localparam logic [OP_W-1:0] OP_LDI = 8'h10;
  localparam logic [OP_W-1:0] OP_ADI = 8'h11;
  localparam logic [OP_W-1:0] OP_LDR = 8'h20;
  localparam logic [OP_W-1:0] OP_ADR = 8'h21;

  typedef struct packed {
    logic              cmd;
    logic [PC_W-1:0]   rom_address;
    logic [WORD_W-1:0] rom_data;
  } in_item_t;

  typedef struct packed {
    logic              out_valid;
    logic [WORD_W-1:0] out_value;
    logic              halted;
    logic [PC_W-1:0]   pc_value;
    logic [WORD_W-1:0] acc_value;
    logic              carry_out;
    logic              zero_out;
  } out_item_t;

  typedef enum logic {
    KIND_EXEC,
    KIND_ROMWR
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [PC_W-1:0]   rom_address;
    logic [WORD_W-1:0] rom_data;
  } q_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MEM
  } state_t;

endpackage

// ===== hw/rtl/acs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module acs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/acs_front.sv =====
// Front end: classifies incoming items and queues them for the back end.
module acs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  acs_pkg::in_item_t  in_data,
  output logic               head_valid,
  output acs_pkg::q_item_t   head,
  input  logic               head_pop
);

  acs_pkg::q_item_t             entries_r [acs_pkg::QDEPTH];
  logic [acs_pkg::QAW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [acs_pkg::QAW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [acs_pkg::QAW:0]        count_r, count_nxt;
  acs_pkg::q_item_t             new_item;
  logic                         push;
  logic                         pop;

  always_comb begin
    new_item.kind        = in_data.cmd ? acs_pkg::KIND_ROMWR : acs_pkg::KIND_EXEC;
    new_item.rom_address = in_data.rom_address;
    new_item.rom_data    = in_data.rom_data;
  end

  assign in_ready   = (count_r != (acs_pkg::QAW+1)'(acs_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entries_r[rd_ptr_r];
  assign push       = in_valid && in_ready;
  assign pop        = head_pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + acs_pkg::QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + acs_pkg::QAW'(1) : rd_ptr_r;
    count_nxt  = count_r + (acs_pkg::QAW+1)'(push) - (acs_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ===== hw/rtl/acs_back.sv =====
// Back end: fetch, memory access and execute of queued items.
module acs_back #(
  parameter int ROM_DEPTH = acs_pkg::ROM_DEPTH_DEF,
  parameter int RAM_DEPTH = acs_pkg::RAM_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  acs_pkg::q_item_t   head,
  output logic               head_pop,
  input  logic               res_ready,
  output logic               res_valid,
  output acs_pkg::out_item_t res
);

  localparam int RAW = $clog2(ROM_DEPTH);
  localparam int DAW = $clog2(RAM_DEPTH);
  localparam int TBL = 2 ** acs_pkg::OP_W;
  localparam int W   = acs_pkg::WORD_W;

  // operand wrap tables, built at elaboration
  logic [RAW-1:0] rom_wrap [TBL];
  logic [DAW-1:0] ram_wrap [TBL];

  genvar gi;
  generate
    for (gi = 0; gi < TBL; gi++) begin : g_wrap
      assign rom_wrap[gi] = RAW'(gi % ROM_DEPTH);
      assign ram_wrap[gi] = DAW'(gi % RAM_DEPTH);
    end
  endgenerate

  acs_pkg::state_t        state_r, state_nxt;
  logic [RAW-1:0]         pc_r, pc_nxt, pc_inc;
  logic [W-1:0]           acc_r, acc_nxt;
  logic                   carry_r, carry_nxt;
  logic                   zero_r, zero_nxt;
  logic                   halt_r, halt_nxt;
  logic [acs_pkg::OP_W-1:0] op_r, op_nxt;

  logic                   rom_vld_r [ROM_DEPTH];
  logic                   ram_vld_r [RAM_DEPTH];
  logic                   rom_rvld_r;
  logic                   ram_rvld_r;

  logic                   rom_we, rom_re;
  logic [RAW-1:0]         rom_waddr, rom_raddr;
  logic [W-1:0]           rom_rdata;
  logic                   ram_we, ram_re;
  logic [DAW-1:0]         ram_addr;
  logic [W-1:0]           ram_rdata;

  logic [W-1:0]           word, rom_word, ram_word, mem_word, add_val;
  logic [acs_pkg::OP_W-1:0] op, arg;
  logic [W:0]             sum;
  logic                   is_mem_op;
  logic                   done;
  logic                   can_take;
  logic                   ovalid;
  logic [W-1:0]           ovalue;

  acs_ram #(.WIDTH(W), .DEPTH(ROM_DEPTH)) u_rom (
    .clk   (clk),
    .we    (rom_we),
    .waddr (rom_waddr),
    .wdata (head.rom_data),
    .re    (rom_re),
    .raddr (rom_raddr),
    .rdata (rom_rdata)
  );

  acs_ram #(.WIDTH(W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (acc_r),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // never-written entries read as zero
  assign word      = rom_rvld_r ? rom_rdata : '0;
  assign rom_word  = word;
  assign ram_word  = ram_rvld_r ? ram_rdata : '0;
  assign op        = word[W-1:acs_pkg::OP_W];
  assign arg       = word[acs_pkg::OP_W-1:0];
  assign ram_addr  = ram_wrap[arg];
  assign rom_waddr = rom_wrap[{1'b0, head.rom_address}];
  assign mem_word  = (op_r == acs_pkg::OP_LDR || op_r == acs_pkg::OP_ADR) ? rom_word : ram_word;
  assign add_val   = (state_r == acs_pkg::ST_MEM) ? mem_word : W'(arg);
  assign sum       = {1'b0, acc_r} + {1'b0, add_val};
  assign pc_inc    = (pc_r == RAW'(ROM_DEPTH - 1)) ? '0 : pc_r + RAW'(1);
  assign is_mem_op = (op == acs_pkg::OP_LDA) || (op == acs_pkg::OP_ADD) ||
                     (op == acs_pkg::OP_LDR) || (op == acs_pkg::OP_ADR);

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    acc_nxt   = acc_r;
    carry_nxt = carry_r;
    zero_nxt  = zero_r;
    halt_nxt  = halt_r;
    op_nxt    = op_r;
    done      = 1'b0;
    ovalid    = 1'b0;
    ovalue    = '0;
    rom_re    = 1'b0;
    rom_raddr = pc_r;
    rom_we    = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    head_pop  = 1'b0;

    case (state_r)
      acs_pkg::ST_FETCH: begin
        if (is_mem_op) begin
          op_nxt    = op;
          pc_nxt    = pc_inc;
          state_nxt = acs_pkg::ST_MEM;
          if (op == acs_pkg::OP_LDR || op == acs_pkg::OP_ADR) begin
            rom_re    = 1'b1;
            rom_raddr = rom_wrap[arg];
          end else begin
            ram_re = 1'b1;
          end
        end else if (res_ready) begin
          done      = 1'b1;
          pc_nxt    = pc_inc;
          state_nxt = acs_pkg::ST_IDLE;
          case (op)
            acs_pkg::OP_STA: ram_we = 1'b1;
            acs_pkg::OP_OUT: begin
              ovalid = 1'b1;
              ovalue = acc_r;
            end
            acs_pkg::OP_JMP: pc_nxt = rom_wrap[arg];
            acs_pkg::OP_JC: begin
              if (carry_r) begin
                pc_nxt = rom_wrap[arg];
              end
            end
            acs_pkg::OP_JZ: begin
              if (zero_r) begin
                pc_nxt = rom_wrap[arg];
              end
            end
            acs_pkg::OP_HLT: begin
              halt_nxt = 1'b1;
              pc_nxt   = pc_r;
            end
            acs_pkg::OP_LDI: acc_nxt = W'(arg);
            acs_pkg::OP_ADI: begin
              acc_nxt   = sum[W-1:0];
              carry_nxt = sum[W];
              zero_nxt  = (sum[W-1:0] == '0);
            end
            default: ;
          endcase
        end
      end
      acs_pkg::ST_MEM: begin
        if (res_ready) begin
          done      = 1'b1;
          state_nxt = acs_pkg::ST_IDLE;
          case (op_r)
            acs_pkg::OP_LDA, acs_pkg::OP_LDR: acc_nxt = mem_word;
            acs_pkg::OP_ADD, acs_pkg::OP_ADR: begin
              acc_nxt   = sum[W-1:0];
              carry_nxt = sum[W];
              zero_nxt  = (sum[W-1:0] == '0);
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // issue: an instruction may start in the cycle another one retires
    can_take = head_valid && (state_r == acs_pkg::ST_IDLE || done);
    if (can_take && head.kind == acs_pkg::KIND_EXEC && !halt_nxt) begin
      head_pop  = 1'b1;
      rom_re    = 1'b1;
      rom_raddr = pc_nxt;
      state_nxt = acs_pkg::ST_FETCH;
    end else if (can_take && state_r == acs_pkg::ST_IDLE && res_ready) begin
      // ROM write, or any item once halted: reports state only
      head_pop = 1'b1;
      done     = 1'b1;
      rom_we   = !halt_r;
    end
  end

  assign res_valid     = done;
  assign res.out_valid = ovalid;
  assign res.out_value = ovalue;
  assign res.halted    = halt_nxt;
  assign res.pc_value  = acs_pkg::PC_W'(pc_nxt);
  assign res.acc_value = acc_nxt;
  assign res.carry_out = carry_nxt;
  assign res.zero_out  = zero_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acs_pkg::ST_IDLE;
      pc_r    <= '0;
      acc_r   <= '0;
      carry_r <= 1'b0;
      zero_r  <= 1'b0;
      halt_r  <= 1'b0;
      for (int i = 0; i < ROM_DEPTH; i++) begin
        rom_vld_r[i] <= 1'b0;
      end
      for (int i = 0; i < RAM_DEPTH; i++) begin
        ram_vld_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      acc_r   <= acc_nxt;
      carry_r <= carry_nxt;
      zero_r  <= zero_nxt;
      halt_r  <= halt_nxt;
      if (rom_we) begin
        rom_vld_r[rom_waddr] <= 1'b1;
      end
      if (ram_we) begin
        ram_vld_r[ram_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    if (rom_re) begin
      rom_rvld_r <= rom_vld_r[rom_raddr];
    end
    if (ram_re) begin
      ram_rvld_r <= ram_vld_r[ram_addr];
    end
  end

`ifndef SYNTH
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared without reset");

  a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res_ready)
    else $error("result produced while output slot busy");

  a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> (!rom_we && !ram_we && !res.out_valid))
    else $error("state changed or OUT reported while halted");

  a_halted_pc: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> $stable(pc_r) && $stable(acc_r))
    else $error("PC or accumulator moved while halted");

  a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> head_valid)
    else $error("pop of empty queue");
`endif

endmodule

// ===== hw/rtl/accumulator_cpu_step.sv =====
// Top level of the accumulator CPU step block: queue, execute unit, output register.
//
// Usage:
//   in_*  : one item per handshake. cmd = 1 writes rom_data into ROM entry rom_address;
//           cmd = 0 executes the instruction at the PC; once halted, neither acts.
//   out_* : exactly one item per input item, in order, carrying the OUT report and
//           the architectural state (halt, PC, accumulator, flags) after that step.
// Steps: a ROM write or any item once halted reports state from idle; an instruction
//   without memory operand does a ROM fetch, then executes; LDA, ADD, LDR and ADR
//   add one more synchronous read after the fetch, before they execute.
// Throughput: one instruction per cycle while the receiver is ready, since the next fetch
//   starts in the cycle the previous one retires; LDA, ADD, LDR and ADR also wait
//   for their second synchronous read. ROM writes wait for the execute unit to be idle.
// A 2-entry item queue keeps taking input while the execute unit works.
// Reset: PC, accumulator and flags clear; both memories read as zero until written
//   (per-entry valid bits), so no clearing pass is needed.
// Stall: when out_ready is low the output register holds, the execute unit waits,
//   the queue fills, and in_ready falls once two items are waiting.
module accumulator_cpu_step #(
  parameter int ROM_DEPTH = acs_pkg::ROM_DEPTH_DEF,
  parameter int RAM_DEPTH = acs_pkg::RAM_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  acs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output acs_pkg::out_item_t out_data
);

  logic               head_valid;
  acs_pkg::q_item_t   head;
  logic               head_pop;
  logic               res_ready;
  logic               res_valid;
  acs_pkg::out_item_t res;

  logic               out_valid_r;
  acs_pkg::out_item_t out_data_r;

  // front: classify and queue items
  acs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  // back: fetch / memory / execute
  acs_back #(
    .ROM_DEPTH (ROM_DEPTH),
    .RAM_DEPTH (RAM_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
